// ===== sv/mpd_pkg.sv =====
// Package with shared constants and types of the predistorter.
`default_nettype none
package mpd_pkg;
    localparam int MEM_DEPTH_DEF   = 4;
    localparam int POLY_ORDER_DEF  = 4;
    localparam int DELAY_MAX_DEF   = 8;
    localparam int SAMPLE_BITS_DEF = 14;
    localparam int BASIS_W = 24;
    localparam int COEF_W  = 16;
    localparam int CIN_W   = 20;
    localparam int ACC_W   = 48;
    localparam int COEF_EPS = 16;
    localparam logic [15:0] GAIN_RST  = 16'd16384;
    localparam logic [14:0] RANGE_RST = 15'd32767;
    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_RANGE = 2'd1;
    localparam logic [1:0] REG_DELAY = 2'd2;
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef struct packed {
        logic              is_coef;
        logic              in_range;
        logic [2:0]        tap;
        logic [2:0]        pw;
        logic signed [15:0] cr;
        logic signed [15:0] ci;
        logic              clip;
        logic signed [13:0] txi;
        logic signed [13:0] txq;
        logic signed [13:0] fbi;
        logic signed [13:0] fbq;
        logic [15:0]       etx;
        logic [15:0]       efb;
    } t_cmd;

    typedef struct packed {
        logic signed [13:0] pd_i;
        logic signed [13:0] pd_q;
        logic signed [13:0] post_i;
        logic signed [13:0] post_q;
        logic signed [13:0] atx_i;
        logic signed [13:0] atx_q;
        logic signed [13:0] apd_i;
        logic signed [13:0] apd_q;
        logic              clip;
    } t_res;
endpackage
`default_nettype wire

// ===== sv/mpd_front.sv =====
// Front stage: classifies items, clamps coefficients and forms envelopes.
`default_nettype none
module mpd_front import mpd_pkg::*; #(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int POLY_ORDER = POLY_ORDER_DEF
) (
    input  wire  [0:0]  i_req_type,
    input  wire  [13:0] i_tx_i,
    input  wire  [13:0] i_tx_q,
    input  wire  [13:0] i_fb_i,
    input  wire  [13:0] i_fb_q,
    input  wire  [2:0]  i_tap,
    input  wire  [2:0]  i_pw,
    input  wire  [19:0] i_cr,
    input  wire  [19:0] i_ci,
    input  wire  [14:0] i_range,
    output t_cmd        o_cmd
);
    function automatic logic [16:0] clampc(input logic signed [19:0] v,
                                           input logic [14:0] r);
        logic signed [20:0] rr;
        logic signed [20:0] x;
        logic c;
        rr = $signed({6'd0, r});
        x = 21'(v);
        c = 1'b0;
        if (x > rr) begin
            x = rr - 21'sd16;
            c = 1'b1;
        end
        if (x < -rr) begin
            x = -rr + 21'sd16;
            c = 1'b1;
        end
        return {c, x[15:0]};
    endfunction

    function automatic logic [15:0] env(input logic signed [13:0] a,
                                        input logic signed [13:0] b);
        logic signed [27:0] sa;
        logic signed [27:0] sb;
        logic [27:0] sq;
        logic [16:0] e;
        sa = 28'(a);
        sb = 28'(b);
        sq = $unsigned(sa * sa) + $unsigned(sb * sb);
        e = sq[27:11];
        return (e > 17'd65535) ? 16'hFFFF : e[15:0];
    endfunction

    logic [16:0] w_r;
    logic [16:0] w_i;

    always_comb begin
        w_r = clampc($signed(i_cr), i_range);
        w_i = clampc($signed(i_ci), i_range);
        o_cmd.is_coef  = (i_req_type == REQ_COEF);
        o_cmd.in_range = (32'(i_tap) <= MEM_DEPTH) && (32'(i_pw) <= POLY_ORDER);
        o_cmd.tap  = i_tap;
        o_cmd.pw   = i_pw;
        o_cmd.cr   = $signed(w_r[15:0]);
        o_cmd.ci   = $signed(w_i[15:0]);
        o_cmd.clip = w_r[16] | w_i[16];
        o_cmd.txi  = $signed(i_tx_i);
        o_cmd.txq  = $signed(i_tx_q);
        o_cmd.fbi  = $signed(i_fb_i);
        o_cmd.fbq  = $signed(i_fb_q);
        o_cmd.etx  = env($signed(i_tx_i), $signed(i_tx_q));
        o_cmd.efb  = env($signed(i_fb_i), $signed(i_fb_q));
    end
endmodule
`default_nettype wire

// ===== sv/mpd_queue.sv =====
// Two-entry queue between the front and back parts.
`default_nettype none
module mpd_queue import mpd_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_wr,
    input  t_cmd  i_data,
    output logic  o_full,
    output logic  o_empty,
    input  wire   i_rd,
    output t_cmd  o_data
);
    t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) r_wp <= ~r_wp;
            if (i_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_wr) - 2'(i_rd);
        end
    end
endmodule
`default_nettype wire

// ===== sv/mpd_back.sv =====
// Back part: basis update, sequential complex multiply-accumulate and output.
`default_nettype none
module mpd_back import mpd_pkg::*; #(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int POLY_ORDER = POLY_ORDER_DEF,
    parameter int DELAY_MAX  = DELAY_MAX_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  t_cmd        i_cmd,
    output logic        o_take,
    input  wire  [15:0] i_gain,
    input  wire  [3:0]  i_delay,
    output logic        o_valid,
    input  wire         i_ready,
    output t_res        o_res
);
    localparam int NPOW  = POLY_ORDER + 1;
    localparam int NCOEF = (MEM_DEPTH + 1) * NPOW;
    localparam int KW    = (NCOEF > 1) ? $clog2(NCOEF) : 1;
    localparam int PW    = (NPOW > 1) ? $clog2(NPOW) : 1;
    localparam int DW    = (DELAY_MAX > 1) ? $clog2(DELAY_MAX) : 1;
    localparam int MW    = COEF_W + BASIS_W;

    typedef enum logic [2:0] {S_IDLE, S_POW, S_MAC, S_SCALE, S_OUT} t_state;

    t_state r_state;
    logic signed [BASIS_W-1:0] r_txr [NCOEF];
    logic signed [BASIS_W-1:0] r_txm [NCOEF];
    logic signed [BASIS_W-1:0] r_fbr [NCOEF];
    logic signed [BASIS_W-1:0] r_fbm [NCOEF];
    logic signed [COEF_W-1:0]  r_cre [NCOEF];
    logic signed [COEF_W-1:0]  r_cim [NCOEF];
    logic signed [13:0] r_dtx_i [DELAY_MAX];
    logic signed [13:0] r_dtx_q [DELAY_MAX];
    logic signed [13:0] r_dpd_i [DELAY_MAX];
    logic signed [13:0] r_dpd_q [DELAY_MAX];
    logic [KW-1:0] r_k;
    logic [PW-1:0] r_p;
    logic signed [ACC_W-1:0] r_tr, r_ti, r_fr, r_fi;
    t_cmd r_cmd;
    t_res r_res;
    logic r_valid;

    function automatic logic signed [13:0] sat14(input logic signed [ACC_W-1:0] v);
        if (v > 48'sd8191) return 14'sd8191;
        if (v < -48'sd8192) return -14'sd8192;
        return v[13:0];
    endfunction

    function automatic logic signed [BASIS_W-1:0] bstep(
        input logic signed [BASIS_W-1:0] b, input logic [15:0] e);
        logic signed [40:0] m;
        logic signed [25:0] s;
        m = b * $signed({1'b0, e});
        s = m[40:15];
        if (s > 26'sd8388607) return 24'sd8388607;
        if (s < -26'sd8388608) return -24'sd8388608;
        return s[23:0];
    endfunction

    logic [3:0] w_dl;
    logic signed [ACC_W-1:0] w_tr, w_ti, w_fr, w_fi;
    logic signed [48:0] w_gr, w_gi;
    logic [KW-1:0] w_idx;
    logic [KW-1:0] w_pi, w_pm;
    logic signed [MW-1:0] w_rr_tx, w_ii_tx, w_ri_tx, w_ir_tx;
    logic signed [MW-1:0] w_rr_fb, w_ii_fb, w_ri_fb, w_ir_fb;

    assign o_take  = (r_state == S_IDLE) && i_valid && !r_valid;
    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign w_dl    = (32'(i_delay) > DELAY_MAX) ? 4'(DELAY_MAX) : i_delay;
    assign w_tr    = r_tr >>> 13;
    assign w_ti    = r_ti >>> 13;
    assign w_fr    = r_fr >>> 13;
    assign w_fi    = r_fi >>> 13;
    assign w_gr    = ($signed(w_tr[31:0]) * $signed({1'b0, i_gain})) >>> 14;
    assign w_gi    = ($signed(w_ti[31:0]) * $signed({1'b0, i_gain})) >>> 14;
    assign w_idx   = KW'(32'(i_cmd.tap) * NPOW + 32'(i_cmd.pw));
    assign w_pi    = KW'(r_p);
    assign w_pm    = KW'(r_p - 1'b1);
    assign w_rr_tx = r_cre[r_k] * r_txr[r_k];
    assign w_ii_tx = r_cim[r_k] * r_txm[r_k];
    assign w_ri_tx = r_cre[r_k] * r_txm[r_k];
    assign w_ir_tx = r_cim[r_k] * r_txr[r_k];
    assign w_rr_fb = r_cre[r_k] * r_fbr[r_k];
    assign w_ii_fb = r_cim[r_k] * r_fbm[r_k];
    assign w_ri_fb = r_cre[r_k] * r_fbm[r_k];
    assign w_ir_fb = r_cim[r_k] * r_fbr[r_k];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            for (int k = 0; k < NCOEF; k++) begin
                r_txr[k] <= '0; r_txm[k] <= '0; r_fbr[k] <= '0; r_fbm[k] <= '0;
                r_cre[k] <= (k == 0) ? 16'sd8192 : '0;
                r_cim[k] <= '0;
            end
            for (int k = 0; k < DELAY_MAX; k++) begin
                r_dtx_i[k] <= '0; r_dtx_q[k] <= '0; r_dpd_i[k] <= '0; r_dpd_q[k] <= '0;
            end
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_take) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.is_coef) begin
                            r_res <= '{clip: i_cmd.in_range & i_cmd.clip, default: '0};
                            if (i_cmd.in_range) begin
                                r_cre[w_idx] <= i_cmd.cr;
                                r_cim[w_idx] <= i_cmd.ci;
                            end
                            r_valid <= 1'b1;
                        end else begin
                            for (int k = NCOEF - 1; k >= NPOW; k--) begin
                                r_txr[k] <= r_txr[k-NPOW]; r_txm[k] <= r_txm[k-NPOW];
                                r_fbr[k] <= r_fbr[k-NPOW]; r_fbm[k] <= r_fbm[k-NPOW];
                            end
                            r_txr[0] <= BASIS_W'(i_cmd.txi);
                            r_txm[0] <= BASIS_W'(i_cmd.txq);
                            r_fbr[0] <= BASIS_W'(i_cmd.fbi);
                            r_fbm[0] <= BASIS_W'(i_cmd.fbq);
                            r_p <= PW'(1);
                            r_state <= (NPOW > 1) ? S_POW : S_MAC;
                            r_k <= '0;
                            r_tr <= '0; r_ti <= '0; r_fr <= '0; r_fi <= '0;
                        end
                    end
                end
                S_POW: begin
                    r_txr[w_pi] <= bstep(r_txr[w_pm], r_cmd.etx);
                    r_txm[w_pi] <= bstep(r_txm[w_pm], r_cmd.etx);
                    r_fbr[w_pi] <= bstep(r_fbr[w_pm], r_cmd.efb);
                    r_fbm[w_pi] <= bstep(r_fbm[w_pm], r_cmd.efb);
                    if (32'(r_p) == NPOW - 1) r_state <= S_MAC;
                    else r_p <= r_p + 1'b1;
                end
                S_MAC: begin
                    r_tr <= r_tr + ACC_W'(w_rr_tx) - ACC_W'(w_ii_tx);
                    r_ti <= r_ti + ACC_W'(w_ri_tx) + ACC_W'(w_ir_tx);
                    r_fr <= r_fr + ACC_W'(w_rr_fb) - ACC_W'(w_ii_fb);
                    r_fi <= r_fi + ACC_W'(w_ri_fb) + ACC_W'(w_ir_fb);
                    if (32'(r_k) == NCOEF - 1) r_state <= S_SCALE;
                    else r_k <= r_k + 1'b1;
                end
                S_SCALE: begin
                    r_res.pd_i   <= sat14(ACC_W'(w_gr));
                    r_res.pd_q   <= sat14(ACC_W'(w_gi));
                    r_res.post_i <= sat14(w_fr);
                    r_res.post_q <= sat14(w_fi);
                    r_res.clip   <= 1'b0;
                    if (w_dl == 4'd0) begin
                        r_res.atx_i <= r_cmd.txi;
                        r_res.atx_q <= r_cmd.txq;
                        r_res.apd_i <= sat14(w_tr);
                        r_res.apd_q <= sat14(w_ti);
                    end else begin
                        r_res.atx_i <= r_dtx_i[DW'(w_dl - 4'd1)];
                        r_res.atx_q <= r_dtx_q[DW'(w_dl - 4'd1)];
                        r_res.apd_i <= r_dpd_i[DW'(w_dl - 4'd1)];
                        r_res.apd_q <= r_dpd_q[DW'(w_dl - 4'd1)];
                    end
                    for (int k = DELAY_MAX - 1; k > 0; k--) begin
                        r_dtx_i[k] <= r_dtx_i[k-1]; r_dtx_q[k] <= r_dtx_q[k-1];
                        r_dpd_i[k] <= r_dpd_i[k-1]; r_dpd_q[k] <= r_dpd_q[k-1];
                    end
                    r_dtx_i[0] <= r_cmd.txi;
                    r_dtx_q[0] <= r_cmd.txq;
                    r_dpd_i[0] <= sat14(w_tr);
                    r_dpd_q[0] <= sat14(w_ti);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/memory_polynomial_predistorter_unit.sv =====
// Top level of the memory-polynomial predistorter.
// Input channel s_axis: each item is a sample pair (tuser = 0) or one
// coefficient write (tuser = 1). Output channel m_axis gives one result
// item for every input item, in order.
// The front part clamps coefficients and forms envelopes in the cycle of
// acceptance and places the item in a two-entry queue. The back part
// updates the basis memory power by power, then runs one shared
// complex multiply-accumulate step per coefficient, then scales and
// saturates into a registered result.
// The back part takes a new item only once it has finished the last one
// and its result has been accepted; the multiply-accumulate loop is the
// longest step of a sample item. A coefficient write is applied and
// answered straight from the idle state.
// Reset clears the basis memory, delay lines and queue, and loads unit
// coefficient, unit gain, full range and zero delay.
// When the receiver stalls, the result holds and the queue fills, after
// which s_axis_tready falls. Configuration must be written only while no
// item is in flight.
`default_nettype none
module memory_polynomial_predistorter_unit import mpd_pkg::*; #(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int POLY_ORDER = POLY_ORDER_DEF,
    parameter int DELAY_MAX  = DELAY_MAX_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: tx_i, tx_q, fb_i, fb_q, coef_tap, coef_power, coef_real, coef_imag
    input  wire  [103:0] s_axis_tdata,
    // tuser: req_type
    input  wire  [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // tdata: pd_i, pd_q, post_i, post_q, aligned_tx_i, aligned_tx_q,
    // aligned_pd_i, aligned_pd_q
    output logic [111:0] m_axis_tdata,
    // tuser: coef_clipped
    output logic [0:0]   m_axis_tuser,
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_addr,
    input  wire  [15:0]  i_cfg_data
);
    logic [15:0] r_gain;
    logic [14:0] r_range;
    logic [3:0]  r_delay;
    t_cmd w_cmd, w_qcmd;
    t_res w_res;
    logic w_full, w_empty, w_take, w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RST;
            r_range <= RANGE_RST;
            r_delay <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_GAIN:  r_gain  <= i_cfg_data;
                REG_RANGE: r_range <= i_cfg_data[14:0];
                REG_DELAY: r_delay <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !w_full;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    mpd_front #(.MEM_DEPTH(MEM_DEPTH), .POLY_ORDER(POLY_ORDER)) u_front (
        .i_req_type(s_axis_tuser),
        .i_tx_i(s_axis_tdata[13:0]),
        .i_tx_q(s_axis_tdata[27:14]),
        .i_fb_i(s_axis_tdata[41:28]),
        .i_fb_q(s_axis_tdata[55:42]),
        .i_tap(s_axis_tdata[58:56]),
        .i_pw(s_axis_tdata[61:59]),
        .i_cr(s_axis_tdata[81:62]),
        .i_ci(s_axis_tdata[101:82]),
        .i_range(r_range),
        .o_cmd(w_cmd)
    );

    mpd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr(w_acc), .i_data(w_cmd),
        .o_full(w_full), .o_empty(w_empty),
        .i_rd(w_take), .o_data(w_qcmd)
    );

    mpd_back #(.MEM_DEPTH(MEM_DEPTH), .POLY_ORDER(POLY_ORDER),
               .DELAY_MAX(DELAY_MAX)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(!w_empty), .i_cmd(w_qcmd), .o_take(w_take),
        .i_gain(r_gain), .i_delay(r_delay),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {w_res.apd_q, w_res.apd_i, w_res.atx_q, w_res.atx_i,
                           w_res.post_q, w_res.post_i, w_res.pd_q, w_res.pd_i};
    assign m_axis_tuser = w_res.clip;

`ifndef SYNTHESIS
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> !w_empty) else $error("queue read while empty");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result lost under stall");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !s_axis_tready) else $error("accept while queue full");
`endif
endmodule
`default_nettype wire
